FILE: hdl/nmea_pkg.sv
// Shared constants, tables and helpers for the NMEA sentence checker.
package nmea_pkg;

    localparam int unsigned LINE_BUFFER_DEPTH = 128;
    localparam int unsigned COUNT_W = 8;

    typedef logic [7:0]         t_byte;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [2:0]         t_kind;

    localparam t_count C_DEPTH      = t_count'(LINE_BUFFER_DEPTH);
    localparam t_count C_STAR_LIMIT = t_count'(75);
    localparam t_count C_PREFIX_LEN = t_count'(6);

    localparam t_byte C_DOLLAR  = 8'h24;
    localparam t_byte C_STAR    = 8'h2A;
    localparam t_byte C_NEWLINE = 8'h0A;
    localparam t_byte C_NUL     = 8'h00;

    localparam t_kind KIND_OTHER = 3'd0;
    localparam t_kind KIND_GPGGA = 3'd1;
    localparam t_kind KIND_GPRMC = 3'd2;
    localparam t_kind KIND_GPGLL = 3'd3;
    localparam t_kind KIND_GPVTG = 3'd4;

    localparam int unsigned NUM_KINDS = 4;

    // Known sentence prefixes, one row per kind, in priority order.
    localparam t_byte C_PREFIX [NUM_KINDS][6] = '{
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},  // $GPGGA
        '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},  // $GPRMC
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},  // $GPGLL
        '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}   // $GPVTG
    };

    // Uppercase ASCII hex digit for one nibble.
    function automatic t_byte f_hex_char(input logic [3:0] nib);
        t_byte c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

FILE: hdl/nmea_sentence_checker.sv
// Top level of the NMEA sentence checker: line assembly and checksum check.
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  -------------------------------------
//  in       sink       i_in_valid / o_in_stall   i_rx_byte
//  out      source     o_out_valid / i_out_stall o_sentence_valid, o_computed_checksum,
//                                                o_sentence_kind, o_line_length,
//                                                o_end_cause
//
//  One item per cycle is taken while the input is not stalled. An item is held in the
//  input register, the line state is updated from it in one pass, and a line end loads
//  the result register, from which the result is presented.
//  Reset (synchronous, active low) empties both registers and clears the line state.
//  A stalled result holds in the result register; bytes that do not end a line keep
//  flowing past it, and only a line-ending byte waits, which then stalls the input.
module nmea_sentence_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  nmea_pkg::t_byte     i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_sentence_valid,
    output nmea_pkg::t_byte     o_computed_checksum,
    output nmea_pkg::t_kind     o_sentence_kind,
    output nmea_pkg::t_count    o_line_length,
    output logic                o_end_cause
);
    import nmea_pkg::*;

    // Scan phases of the line checker
    localparam logic [2:0] PH_START = 3'd0;  // awaiting the first byte
    localparam logic [2:0] PH_SUM   = 3'd1;  // accumulating the checksum
    localparam logic [2:0] PH_HI    = 3'd2;  // expecting the high hex digit
    localparam logic [2:0] PH_LO    = 3'd3;  // expecting the low hex digit
    localparam logic [2:0] PH_DONE  = 3'd4;  // both digits seen
    localparam logic [2:0] PH_FAIL  = 3'd5;  // line cannot be valid

    // Input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // Line state
    t_count              r_count,  n_count;
    logic [2:0]          r_phase,  n_phase;
    t_byte               r_sum,    n_sum;
    logic [1:0]          r_digits, n_digits;
    logic [NUM_KINDS-1:0] r_prefix, n_prefix;

    // Result register
    logic   r_out_valid;
    logic   r_res_valid;
    t_byte  r_res_sum;
    t_kind  r_res_kind;
    t_count r_res_len;
    logic   r_res_cause;

    logic  ends_line;
    logic  proc_fire;
    logic  in_accept;
    logic  res_valid;
    t_kind res_kind;

    // A byte ends the line when it is a newline or the buffer is already full.
    assign ends_line = (r_in_byte == C_NEWLINE) || (r_count >= C_DEPTH);
    // Hold a line-ending byte only while the result register is occupied and stalled.
    assign proc_fire = r_in_valid && (!ends_line || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Result of the line being closed
    always_comb begin
        res_valid = (r_phase == PH_DONE) && (r_digits == 2'b11);
        res_kind  = KIND_OTHER;
        if (r_count >= C_PREFIX_LEN) begin
            // Walk from lowest priority upwards so the first matching row wins.
            for (int k = NUM_KINDS - 1; k >= 0; k--) begin
                if (r_prefix[k]) begin
                    res_kind = t_kind'(k + 1);
                end
            end
        end
    end

    // Per-byte update of the line state
    always_comb begin
        n_count  = r_count;
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_digits = r_digits;
        n_prefix = r_prefix;

        if (ends_line) begin
            // Clear everything ready for the next line; the ending byte is dropped.
            n_count  = '0;
            n_phase  = PH_START;
            n_sum    = '0;
            n_digits = '0;
            n_prefix = '1;
        end else begin
            // Drop any prefix whose character at this position differs.
            if (r_count < C_PREFIX_LEN) begin
                for (int k = 0; k < NUM_KINDS; k++) begin
                    if (C_PREFIX[k][r_count[2:0]] != r_in_byte) begin
                        n_prefix[k] = 1'b0;
                    end
                end
            end

            unique case (r_phase)
                PH_START: begin
                    n_phase = (r_in_byte == C_DOLLAR) ? PH_SUM : PH_FAIL;
                end
                PH_SUM: begin
                    if (r_in_byte == C_NUL) begin
                        n_phase = PH_FAIL;           // text ends before the star
                    end else if (r_count >= C_STAR_LIMIT) begin
                        n_phase = PH_FAIL;           // sentence too long
                    end else if (r_in_byte == C_STAR) begin
                        n_phase = PH_HI;
                    end else begin
                        n_sum = r_sum ^ r_in_byte;
                    end
                end
                PH_HI: begin
                    if (r_in_byte == f_hex_char(r_sum[7:4])) begin
                        n_digits[0] = 1'b1;
                    end
                    n_phase = PH_LO;
                end
                PH_LO: begin
                    if (r_in_byte == f_hex_char(r_sum[3:0])) begin
                        n_digits[1] = 1'b1;
                    end
                    n_phase = PH_DONE;
                end
                PH_DONE, PH_FAIL: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_FAIL;
                end
            endcase

            n_count = r_count + t_count'(1);
        end
    end

    // Input register: load on accept, empty once the item has been used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Line state: advance once per consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_phase  <= PH_START;
            r_sum    <= '0;
            r_digits <= '0;
            r_prefix <= '1;
        end else if (proc_fire) begin
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_sum    <= n_sum;
            r_digits <= n_digits;
            r_prefix <= n_prefix;
        end
    end

    // Result register: load at a line end, empty once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && ends_line) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc_fire && ends_line) begin
            r_res_valid <= res_valid;
            r_res_sum   <= r_sum;
            r_res_kind  <= res_kind;
            r_res_len   <= r_count;
            r_res_cause <= (r_in_byte != C_NEWLINE);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_sentence_valid    = r_res_valid;
    assign o_computed_checksum = r_res_sum;
    assign o_sentence_kind     = r_res_kind;
    assign o_line_length       = r_res_len;
    assign o_end_cause         = r_res_cause;

    // The line buffer never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_DEPTH)
        else $error("stored byte count beyond buffer depth");

    // Closing a line restarts the count
    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && ends_line) |=> (r_count == '0) && (r_phase == PH_START))
        else $error("line state not cleared after line end");

    // A valid sentence holds at least dollar, star and two digits
    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && ends_line && res_valid) |-> (r_count >= t_count'(4)))
        else $error("valid sentence shorter than four bytes");

    // The input only stalls behind a held line-ending byte
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && ends_line && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked line end");

endmodule

FILE: bench/nmea_sentence_checker_chk.sv
// Line-result predictor and scoreboard for the NMEA sentence checker bench.
module nmea_sentence_checker_chk (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  nmea_pkg::t_byte   i_rx_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_sentence_valid,
    input  nmea_pkg::t_byte   i_computed_checksum,
    input  nmea_pkg::t_kind   i_sentence_kind,
    input  nmea_pkg::t_count  i_line_length,
    input  logic              i_end_cause,
    output int                o_fail_count,
    output int                o_pending
);
    import nmea_pkg::*;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SUM,
        SCAN_HI,
        SCAN_LO,
        SCAN_DONE,
        SCAN_FAIL
    } t_scan;

    typedef struct packed {
        logic   ok;
        t_byte  sum;
        t_kind  kind;
        t_count len;
        logic   cause;
    } t_line_result;

    // Predicted line state
    t_count       line_count;
    t_scan        scan;
    t_byte        xor_sum;
    logic [1:0]   digit_hits;
    logic [3:0]   prefix_hits;

    t_line_result line_results_q[$];
    t_line_result seen;
    t_line_result want;
    int           fail_n;
    string        hex_digits = "0123456789ABCDEF";

    function automatic void clear_line();
        line_count  = '0;
        scan        = SCAN_START;
        xor_sum     = '0;
        digit_hits  = '0;
        prefix_hits = 4'hF;
    endfunction

    // Advance the line state by one byte; return 1 with the result when the line ends.
    function automatic bit take_byte(input t_byte b, output t_line_result r);
        int k;
        r = '0;
        if (b != C_NEWLINE && line_count < C_DEPTH) begin
            if (line_count < C_PREFIX_LEN) begin
                for (k = 0; k < NUM_KINDS; k++) begin
                    if (C_PREFIX[k][line_count] != b) begin
                        prefix_hits[k] = 1'b0;
                    end
                end
            end
            case (scan)
                SCAN_START: begin
                    scan = (b == C_DOLLAR) ? SCAN_SUM : SCAN_FAIL;
                end
                SCAN_SUM: begin
                    if (b == C_NUL || line_count >= C_STAR_LIMIT) begin
                        scan = SCAN_FAIL;
                    end else if (b == C_STAR) begin
                        scan = SCAN_HI;
                    end else begin
                        xor_sum = xor_sum ^ b;
                    end
                end
                SCAN_HI: begin
                    if (b == hex_digits[xor_sum[7:4]]) digit_hits[0] = 1'b1;
                    scan = SCAN_LO;
                end
                SCAN_LO: begin
                    if (b == hex_digits[xor_sum[3:0]]) digit_hits[1] = 1'b1;
                    scan = SCAN_DONE;
                end
                default: ;
            endcase
            line_count = line_count + t_count'(1);
            return 1'b0;
        end

        r.ok   = (scan == SCAN_DONE) && (digit_hits == 2'b11);
        r.sum  = xor_sum;
        r.kind = KIND_OTHER;
        if (line_count >= C_PREFIX_LEN) begin
            if (prefix_hits[0])      r.kind = KIND_GPGGA;
            else if (prefix_hits[1]) r.kind = KIND_GPRMC;
            else if (prefix_hits[2]) r.kind = KIND_GPGLL;
            else if (prefix_hits[3]) r.kind = KIND_GPVTG;
        end
        r.len   = line_count;
        r.cause = (b != C_NEWLINE);
        clear_line();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            fail_n++;
        end
    endtask

    initial begin
        clear_line();
        fail_n = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (line_results_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got length %0d", $time,
                             i_line_length);
                    fail_n++;
                end else begin
                    want = line_results_q.pop_front();
                    check_field("sentence_valid", 8'(want.ok), 8'(i_sentence_valid));
                    check_field("computed_checksum", want.sum, i_computed_checksum);
                    check_field("sentence_kind", 8'(want.kind), 8'(i_sentence_kind));
                    check_field("line_length", want.len, i_line_length);
                    check_field("end_cause", 8'(want.cause), 8'(i_end_cause));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (take_byte(i_rx_byte, seen)) line_results_q.push_back(seen);
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= line_results_q.size();
    end

endmodule

FILE: bench/nmea_sentence_checker_tb.sv
// Bench top: feeds NMEA byte lines to the sentence checker and reports the verdict.
module nmea_sentence_checker_tb;
    import nmea_pkg::*;

    // Kinds of line the stimulus can build
    typedef enum {
        LINE_GOOD,
        LINE_BAD_DIGIT,
        LINE_LOWER_HEX,
        LINE_SHORT_DIGITS,
        LINE_NUL,
        LINE_NO_DOLLAR,
        LINE_NOISE,
        LINE_FULL_NL,
        LINE_FULL_DROP
    } t_line_style;

    localparam int TARGET_BYTES = 1900;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int CLK_PERIOD   = 20;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_byte  i_rx_byte;
    logic   o_out_valid;
    logic   i_out_stall;
    logic   o_sentence_valid;
    t_byte  o_computed_checksum;
    t_kind  o_sentence_kind;
    t_count o_line_length;
    logic   o_end_cause;

    int     fail_count;
    int     pending;
    t_byte  line_bytes[$];
    int     sent_bytes;
    bit     calm;

    nmea_sentence_checker DUT (.*);

    nmea_sentence_checker_chk u_chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_rx_byte           (i_rx_byte),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_sentence_valid    (o_sentence_valid),
        .i_computed_checksum (o_computed_checksum),
        .i_sentence_kind     (o_sentence_kind),
        .i_line_length       (o_line_length),
        .i_end_cause         (o_end_cause),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or loses a result
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    // Random body byte: with any_byte, anything but a newline; else mostly printable,
    // now and then top bit set, never a star, so stars land only where the builder puts them.
    function automatic t_byte filler(input bit any_byte);
        t_byte c;
        if (any_byte) begin
            c = t_byte'($urandom);
            if (c == C_NEWLINE) c = 8'h0B;
        end else if ($urandom_range(0, 19) == 0) begin
            c = t_byte'($urandom_range(128, 255));
        end else begin
            c = t_byte'($urandom_range(32, 126));
            if (c == C_STAR) c = 8'h2C;
        end
        return c;
    endfunction

    function automatic t_byte digit_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return t_byte'(8'h30 + nib);
        return t_byte'((lower ? 8'h61 : 8'h41) + nib - 4'd10);
    endfunction

    // Build one line into line_bytes. Kind 0 gives a random five-letter talker/type,
    // 1..4 the known prefixes; body_len is the number of bytes between prefix and star.
    function automatic void build_line(input t_line_style style, input int kind_sel,
                                       input int body_len);
        t_byte      sum;
        t_byte      c;
        int         n;
        int         nul_at;
        logic [3:0] delta;
        line_bytes.delete();
        sum = '0;

        if (style == LINE_NOISE) begin
            for (n = 0; n < body_len; n++) line_bytes.push_back(filler(1'b1));
            if (body_len > 0 && $urandom_range(0, 2) == 0) line_bytes[0] = C_DOLLAR;
            line_bytes.push_back(C_NEWLINE);
            return;
        end

        // Opening byte: a letter in place of the dollar for the unanchored case
        if (style == LINE_NO_DOLLAR) line_bytes.push_back(t_byte'($urandom_range(65, 90)));
        else line_bytes.push_back(C_DOLLAR);

        for (n = 1; n < 6; n++) begin
            c = (kind_sel > 0) ? C_PREFIX[kind_sel-1][n] : t_byte'($urandom_range(65, 90));
            line_bytes.push_back(c);
            sum = sum ^ c;
        end

        // Fill the buffer to the brim, then end it by newline or by a dropped byte
        if (style == LINE_FULL_NL || style == LINE_FULL_DROP) begin
            while (line_bytes.size() < LINE_BUFFER_DEPTH) line_bytes.push_back(filler(1'b0));
            line_bytes.push_back(style == LINE_FULL_NL ? C_NEWLINE
                                                       : t_byte'($urandom_range(11, 255)));
            return;
        end

        nul_at = (style == LINE_NUL) ? int'($urandom_range(0, body_len)) : -1;
        for (n = 0; n <= body_len; n++) begin
            if (n == nul_at) line_bytes.push_back(C_NUL);
            if (n < body_len) begin
                c = filler(1'b0);
                line_bytes.push_back(c);
                sum = sum ^ c;
            end
        end
        line_bytes.push_back(C_STAR);

        case (style)
            LINE_SHORT_DIGITS: begin
                if ($urandom_range(0, 1)) line_bytes.push_back(digit_char(sum[7:4], 1'b0));
            end
            LINE_BAD_DIGIT: begin
                delta = 4'($urandom_range(1, 15));
                if ($urandom_range(0, 1)) begin
                    line_bytes.push_back(digit_char(sum[7:4] ^ delta, 1'b0));
                    line_bytes.push_back(digit_char(sum[3:0], 1'b0));
                end else begin
                    line_bytes.push_back(digit_char(sum[7:4], 1'b0));
                    line_bytes.push_back(digit_char(sum[3:0] ^ delta, 1'b0));
                end
            end
            LINE_LOWER_HEX: begin
                line_bytes.push_back(digit_char(sum[7:4], 1'b1));
                line_bytes.push_back(digit_char(sum[3:0], 1'b1));
            end
            default: begin
                line_bytes.push_back(digit_char(sum[7:4], 1'b0));
                line_bytes.push_back(digit_char(sum[3:0], 1'b0));
            end
        endcase

        // Trailer: occasional junk after the digits, and a carriage return half the time
        if (style != LINE_SHORT_DIGITS) begin
            if ($urandom_range(0, 9) == 0) line_bytes.push_back(filler(1'b0));
            if ($urandom_range(0, 1)) line_bytes.push_back(8'h0D);
        end
        line_bytes.push_back(C_NEWLINE);
    endfunction

    // Drive every byte of line_bytes, with random idle gaps unless the line is calm.
    // Change inputs on the falling edge; hold each byte until taken at a rising edge.
    task automatic send_line();
        int gap;
        int r;
        foreach (line_bytes[i]) begin
            r = $urandom_range(0, 99);
            if (calm || r < 70) gap = 0;
            else if (r < 93) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 40);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_rx_byte  <= t_byte'($urandom);
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_rx_byte  <= line_bytes[i];
            do @(posedge i_clk); while (o_in_stall);
            sent_bytes++;
        end
    endtask

    task automatic drive_line(input t_line_style style, input int kind_sel,
                              input int body_len);
        build_line(style, kind_sel, body_len);
        send_line();
    endtask

    // Output back-pressure: mostly free, short stalls, the odd long one and quiet spells
    initial begin : out_stall_gen
        int hold;
        int quiet;
        int r;
        hold        = 0;
        quiet       = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (quiet > 0) begin
                quiet--;
                i_out_stall <= 1'b0;
            end else if (r < 3) begin
                hold = $urandom_range(10, 40);
                i_out_stall <= 1'b1;
            end else if (r < 25) begin
                hold = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else if (r < 28) begin
                quiet = $urandom_range(30, 200);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int          r;
        int          kind_sel;
        int          body_len;
        t_line_style style;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte  = '0;
        sent_bytes = 0;
        calm       = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: each known kind, an unknown kind, and the special cases
        drive_line(LINE_GOOD, 1, 8);
        drive_line(LINE_GOOD, 2, 0);
        drive_line(LINE_GOOD, 3, 15);
        drive_line(LINE_GOOD, 4, 30);
        drive_line(LINE_GOOD, 0, 10);
        drive_line(LINE_NO_DOLLAR, 1, 6);         // no leading dollar
        drive_line(LINE_NUL, 2, 10);              // text cut short by NUL
        drive_line(LINE_GOOD, 3, 68);             // star on the last index allowed
        drive_line(LINE_GOOD, 3, 69);             // star one index too far
        drive_line(LINE_SHORT_DIGITS, 4, 5);      // line ends before both digits
        drive_line(LINE_BAD_DIGIT, 1, 5);
        drive_line(LINE_LOWER_HEX, 2, 5);
        drive_line(LINE_NOISE, 0, 0);             // empty line
        line_bytes = '{8'hFF, C_NUL, 8'h80, 8'h7F, C_NEWLINE};
        send_line();
        line_bytes = '{C_DOLLAR, 8'h47, 8'h50, 8'h47, 8'h47, C_NEWLINE};  // too short for a kind
        send_line();
        drive_line(LINE_FULL_NL, 1, 0);           // newline on a full buffer
        drive_line(LINE_FULL_DROP, 2, 0);         // full buffer, extra byte dropped

        // Random: mostly well-formed sentences with random content, mixed with broken ones
        while (sent_bytes < TARGET_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 60)      style = LINE_GOOD;
            else if (r < 66) style = LINE_BAD_DIGIT;
            else if (r < 70) style = LINE_LOWER_HEX;
            else if (r < 75) style = LINE_SHORT_DIGITS;
            else if (r < 79) style = LINE_NUL;
            else if (r < 84) style = LINE_NO_DOLLAR;
            else if (r < 97) style = LINE_NOISE;
            else if (r < 98) style = LINE_FULL_NL;
            else             style = LINE_FULL_DROP;
            kind_sel = $urandom_range(0, 4);
            body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 85)
                                                   : $urandom_range(0, 40);
            if (style == LINE_NOISE) body_len = $urandom_range(0, 30);
            calm = ($urandom_range(0, 3) == 0);
            drive_line(style, kind_sel, body_len);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain: wait for every expected result, then allow the pipeline to settle
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
